// File: rtl/core/rgbp_pkg.sv
// rgbp_pkg: shared widths, register codes, reset values and structs of the
// radix group byte packer. No dependencies.
package rgbp_pkg;

  // field and state widths
  localparam int COEF_W     = 16;
  localparam int MOD_W      = 17;
  localparam int GSIZE_W    = 3;
  localparam int GBITS_W    = 7;
  localparam int GCOUNT_W   = 3;
  localparam int ACC_W      = 64;
  localparam int HALF_W     = 32;
  localparam int PLO_W      = HALF_W + MOD_W;
  localparam int BYTE_W     = 8;
  localparam int CARRY_W    = 7;
  localparam int CCNT_W     = 3;
  localparam int STREAM_W   = ACC_W + BYTE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // limits of the group registers
  localparam int MAX_GROUP  = 4;
  localparam int GBITS_MIN  = 8;
  localparam int GBITS_MAX  = 64;

  // default depth of the front-to-back queue
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_BITS = 2'd2;

  // register reset values
  localparam logic [MOD_W-1:0]   MODULUS_RST    = 17'd12289;
  localparam logic [GSIZE_W-1:0] GROUP_SIZE_RST = 3'd4;
  localparam logic [GBITS_W-1:0] GROUP_BITS_RST = 7'd55;

  // effective configuration seen by the datapath
  typedef struct packed {
    logic [MOD_W-1:0]   modulus;
    logic [GSIZE_W-1:0] group_size;
    logic [GBITS_W-1:0] group_bits;
  } cfg_t;

  // classified coefficient held in the queue
  typedef struct packed {
    logic [COEF_W-1:0] coef;
    logic              close;
    logic              fin;
  } q_item_t;

  // closed group handed from the accumulator to the serializer
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] word;
    logic             fin;
  } grp_t;

endpackage

// File: rtl/core/rgbp_in_if.sv
// rgbp_in_if: coefficient input channel with valid/ready handshake.
// Depends on rgbp_pkg for field widths.
interface rgbp_in_if;
  import rgbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [COEF_W-1:0] coefficient;
  logic              final_coeff;

  modport source (output valid, output coefficient, output final_coeff, input ready);
  modport sink   (input valid, input coefficient, input final_coeff, output ready);
endinterface

// File: rtl/core/rgbp_out_if.sv
// rgbp_out_if: packed byte output channel with valid/ready handshake.
// Depends on rgbp_pkg for field widths.
interface rgbp_out_if;
  import rgbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_end;

  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink   (input valid, input out_byte, input run_end, output ready);
endinterface

// File: rtl/core/rgbp_cfg_if.sv
// rgbp_cfg_if: register write channel carrying index and write data.
// Depends on rgbp_pkg for field widths.
interface rgbp_cfg_if;
  import rgbp_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/rgbp_front.sv
// rgbp_front: accepts coefficients, tracks group membership and marks the
// coefficient that closes a group. Depends on rgbp_pkg and rgbp_in_if.
module rgbp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  rgbp_pkg::cfg_t    cfg,
  rgbp_in_if.sink           in_chan,
  output logic              q_push,
  output rgbp_pkg::q_item_t q_item,
  input  logic              q_ready
);
  import rgbp_pkg::*;

  logic [GCOUNT_W-1:0] count_r;
  logic [GCOUNT_W-1:0] count_nxt;
  logic [GCOUNT_W-1:0] count_inc;
  logic                close;

  // accept whenever the queue has room
  assign in_chan.ready = q_ready;
  assign q_push        = in_chan.valid && q_ready;

  // a group closes on its last member or on the vector's final coefficient
  assign count_inc = count_r + GCOUNT_W'(1);
  assign close     = in_chan.final_coeff || (count_inc >= cfg.group_size);

  assign q_item.coef  = in_chan.coefficient;
  assign q_item.close = close;
  assign q_item.fin   = in_chan.final_coeff;

  // member count of the open group
  always_comb begin
    count_nxt = count_r;
    if (q_push) begin
      count_nxt = close ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end
endmodule

// File: rtl/core/rgbp_queue.sv
// rgbp_queue: small fifo of classified coefficients between front and back.
// Depends on rgbp_pkg for the item struct.
module rgbp_queue #(
  parameter int DEPTH = rgbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rgbp_pkg::q_item_t push_item,
  output logic              push_ready,
  output logic              pop_valid,
  output rgbp_pkg::q_item_t pop_item,
  input  logic              pop
);
  import rgbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  q_item_t          mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (cnt_r != FULL_CNT);
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end
endmodule

// File: rtl/core/rgbp_accum.sv
// rgbp_accum: folds coefficients into the base-modulus group value with one
// shared 32x17 multiplier, used for each half in turn. Depends on rgbp_pkg.
module rgbp_accum (
  input  logic              clk,
  input  logic              rst_n,
  input  rgbp_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rgbp_pkg::q_item_t q_item,
  output logic              q_pop,
  output rgbp_pkg::grp_t    grp,
  input  logic              grp_ready
);
  import rgbp_pkg::*;

  localparam logic ST_LO = 1'b0;
  localparam logic ST_HI = 1'b1;

  logic             state_r;
  logic [ACC_W-1:0] gv_r;
  logic [PLO_W-1:0] plo_r;
  q_item_t          item_r;
  logic             gvalid_r;
  logic [ACC_W-1:0] gword_r;
  logic             gfin_r;

  logic [HALF_W-1:0] mul_a;
  logic [PLO_W-1:0]  prod;
  logic [ACC_W-1:0]  sum;
  logic              hand_off;

  // one multiplier: low half of the group value first, high half second
  assign mul_a = (state_r == ST_LO) ? gv_r[HALF_W-1:0] : gv_r[ACC_W-1:HALF_W];
  assign prod  = PLO_W'({{MOD_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, cfg.modulus});

  // value * modulus + coefficient, wrapping at 64 bits
  assign sum = {{(ACC_W-PLO_W){1'b0}}, plo_r}
             + {prod[HALF_W-1:0], {HALF_W{1'b0}}}
             + {{(ACC_W-COEF_W){1'b0}}, item_r.coef};

  assign q_pop    = (state_r == ST_LO) && q_valid;
  assign hand_off = (state_r == ST_HI) && item_r.close && !gvalid_r;

  assign grp.valid = gvalid_r;
  assign grp.word  = gword_r;
  assign grp.fin   = gfin_r;

  // low partial product, item capture and hand-off word
  always_ff @(posedge clk) begin
    if (q_pop) begin
      plo_r  <= prod;
      item_r <= q_item;
    end
    if (hand_off) begin
      gword_r <= sum;
      gfin_r  <= item_r.fin;
    end
  end

  // sequencing, group value and hand-off slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LO;
      gv_r     <= '0;
      gvalid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_LO: begin
          if (q_pop) begin
            state_r <= ST_HI;
          end
        end
        ST_HI: begin
          if (!item_r.close) begin
            gv_r    <= sum;
            state_r <= ST_LO;
          end else if (hand_off) begin
            gv_r    <= '0;
            state_r <= ST_LO;
          end
        end
        default: begin
          state_r <= ST_LO;
        end
      endcase
      if (hand_off) begin
        gvalid_r <= 1'b1;
      end else if (gvalid_r && grp_ready) begin
        gvalid_r <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/core/rgbp_serial.sv
// rgbp_serial: writes closed groups into the LSB-first byte stream, one byte a cycle while
// the output is ready, keeping leftover bits for the next group. Depends on rgbp_pkg, rgbp_out_if.
module rgbp_serial (
  input  logic           clk,
  input  logic           rst_n,
  input  rgbp_pkg::cfg_t cfg,
  input  rgbp_pkg::grp_t grp,
  output logic           grp_ready,
  rgbp_out_if.source     out_chan
);
  import rgbp_pkg::*;

  logic                busy_r;
  logic [STREAM_W-1:0] stream_r;
  logic [GBITS_W-1:0]  left_r;
  logic                fin_r;
  logic [CARRY_W-1:0]  carry_r;
  logic [CCNT_W-1:0]   ccnt_r;
  logic                ovalid_r;
  logic [BYTE_W-1:0]   obyte_r;
  logic                oend_r;

  logic                load;
  logic                emit;
  logic                last;
  logic [CCNT_W-1:0]   rem;
  logic [CARRY_W-1:0]  rem_mask;
  logic [STREAM_W-1:0] stream_ld;

  assign grp_ready = !busy_r;
  assign load      = grp.valid && !busy_r;
  assign emit      = busy_r && (!ovalid_r || out_chan.ready);

  // new group placed above the carried bits
  assign stream_ld = ({{BYTE_W{1'b0}}, grp.word} << ccnt_r)
                   | {{(STREAM_W-CARRY_W){1'b0}}, carry_r};

  // last byte when fewer than eight bits follow it
  assign last     = (left_r < GBITS_W'(2 * BYTE_W));
  assign rem      = left_r[CCNT_W-1:0];
  assign rem_mask = CARRY_W'((8'd1 << rem) - 8'd1);

  assign out_chan.valid    = ovalid_r;
  assign out_chan.out_byte = obyte_r;
  assign out_chan.run_end  = oend_r;

  // stream payload and output byte
  always_ff @(posedge clk) begin
    if (load) begin
      stream_r <= stream_ld;
      left_r   <= cfg.group_bits + GBITS_W'(ccnt_r);
      fin_r    <= grp.fin;
    end else if (emit) begin
      stream_r <= stream_r >> BYTE_W;
      left_r   <= left_r - GBITS_W'(BYTE_W);
    end
    if (emit) begin
      obyte_r <= stream_r[BYTE_W-1:0];
      oend_r  <= last;
    end
  end

  // control and carry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      carry_r  <= '0;
      ccnt_r   <= '0;
    end else begin
      if (load) begin
        busy_r <= 1'b1;
      end else if (emit && last) begin
        busy_r <= 1'b0;
        if (fin_r) begin
          carry_r <= '0;
          ccnt_r  <= '0;
        end else begin
          carry_r <= stream_r[2*BYTE_W-2:BYTE_W] & rem_mask;
          ccnt_r  <= rem;
        end
      end
      if (emit) begin
        ovalid_r <= 1'b1;
      end else if (out_chan.ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end
endmodule

// File: rtl/core/radix_group_byte_packer.sv
// radix_group_byte_packer: top level with configuration registers, front,
// queue, accumulator and serializer. Depends on rgbp_pkg and the channel interfaces.
//
// Packs coefficients in groups of group_size into base-modulus numbers (first
// coefficient most significant) and writes each group as a group_bits-bit
// field into an LSB-first byte stream; leftover bits carry into the next group
// and are dropped after the coefficient marked final_coeff. Each coefficient passes
// the accumulator, whose 64-bit multiply-add runs on one shared 32x17 multiplier;
// a closed group is then loaded into the serializer and leaves as 1 to 8 bytes, one
// a cycle while the output is ready, as the accumulator works on the next group. A
// coefficient that closes no group gives no byte. The input side accepts while the
// queue has room. Registers take effect at once; the user must write them only while
// the block is idle, which the block does not enforce; there is no clearing pass.
module radix_group_byte_packer #(
  parameter int QUEUE_DEPTH = rgbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rgbp_in_if.sink    in_chan,
  rgbp_out_if.source out_chan,
  rgbp_cfg_if.sink   cfg_chan
);
  import rgbp_pkg::*;

  logic [MOD_W-1:0]   modulus_r;
  logic [GSIZE_W-1:0] group_size_r;
  logic [GBITS_W-1:0] group_bits_r;
  cfg_t               cfg;

  logic    q_push;
  q_item_t q_in;
  logic    q_push_ready;
  logic    q_valid;
  q_item_t q_out;
  logic    q_pop;
  grp_t    grp;
  logic    grp_ready;

  // register writes
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r    <= MODULUS_RST;
      group_size_r <= GROUP_SIZE_RST;
      group_bits_r <= GROUP_BITS_RST;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_MODULUS:    modulus_r    <= cfg_chan.data;
        REG_GROUP_SIZE: group_size_r <= cfg_chan.data[GSIZE_W-1:0];
        REG_GROUP_BITS: group_bits_r <= cfg_chan.data[GBITS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // clamp group size and group width to their legal ranges
  always_comb begin
    cfg.modulus = modulus_r;
    if (group_size_r == '0) begin
      cfg.group_size = GSIZE_W'(1);
    end else if (group_size_r > GSIZE_W'(MAX_GROUP)) begin
      cfg.group_size = GSIZE_W'(MAX_GROUP);
    end else begin
      cfg.group_size = group_size_r;
    end
    if (group_bits_r < GBITS_W'(GBITS_MIN)) begin
      cfg.group_bits = GBITS_W'(GBITS_MIN);
    end else if (group_bits_r > GBITS_W'(GBITS_MAX)) begin
      cfg.group_bits = GBITS_W'(GBITS_MAX);
    end else begin
      cfg.group_bits = group_bits_r;
    end
  end

  rgbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_chan (in_chan),
    .q_push  (q_push),
    .q_item  (q_in),
    .q_ready (q_push_ready)
  );

  rgbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_in),
    .push_ready (q_push_ready),
    .pop_valid  (q_valid),
    .pop_item   (q_out),
    .pop        (q_pop)
  );

  rgbp_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .grp       (grp),
    .grp_ready (grp_ready)
  );

  rgbp_serial u_serial (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .grp       (grp),
    .grp_ready (grp_ready),
    .out_chan  (out_chan)
  );

  // a final coefficient always closes its group
  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready && in_chan.final_coeff) |-> q_in.close)
    else $error("final coefficient not marked as closing its group");

  // checks that a group taken by the serializer is followed by a valid output byte
  a_group_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (grp.valid && grp_ready) |-> ##2 out_chan.valid)
    else $error("closed group produced no output byte");

  // nothing is shown at the output right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("output valid right after reset");
endmodule
